// File: src/cfpw_pkg.sv
package cfpw_pkg;

  localparam int SYM_W   = 8;
  localparam int VAL_W   = 16;
  localparam int DRIVE_W = 13;
  localparam int CNT_W   = 3;
  localparam int NUM_PAT = 5;
  localparam int PAT_MAX = 8;

  localparam logic [SYM_W-1:0] SYM_A     = 8'h41;
  localparam logic [SYM_W-1:0] SYM_GT    = 8'h3E;
  localparam logic [SYM_W-1:0] SYM_COMMA = 8'h2C;
  localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h30;
  localparam logic [SYM_W-1:0] SYM_NINE  = 8'h39;
  localparam logic [SYM_W-1:0] SYM_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] SYM_TAB   = 8'h09;
  localparam logic [SYM_W-1:0] SYM_CR    = 8'h0D;

  localparam logic [VAL_W-1:0] VAL_MAX       = 16'hFFFF;
  localparam logic [VAL_W-1:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [VAL_W-1:0] THRESH_RESET  = 16'd1000;

  // x/10 for any 16 bit x as (x * 52429) >> 19
  localparam logic [16:0] DIV10_MUL   = 17'd52429;
  localparam int          DIV10_SHIFT = 19;

  // register indexes of the configuration port
  localparam int          CFG_IDX_W     = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b1;

  // command patterns
  localparam int PAT_RS  = 0;
  localparam int PAT_WL1 = 1;
  localparam int PAT_WL0 = 2;
  localparam int PAT_WLQ = 3;
  localparam int PAT_AT  = 4;

  localparam logic [SYM_W-1:0] PAT_TEXT [NUM_PAT][PAT_MAX] = '{
    '{8'h41, 8'h54, 8'h52, 8'h53, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h41, 8'h54, 8'h57, 8'h4C, 8'h3D, 8'h31, 8'h00, 8'h00},
    '{8'h41, 8'h54, 8'h57, 8'h4C, 8'h3D, 8'h30, 8'h00, 8'h00},
    '{8'h41, 8'h54, 8'h57, 8'h4C, 8'h3F, 8'h00, 8'h00, 8'h00},
    '{8'h41, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [CNT_W-1:0] PAT_LEN [NUM_PAT] = '{3'd4, 3'd6, 3'd6, 3'd5, 3'd2};

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_CMD   = 2'd1,
    KIND_DRIVE = 2'd2,
    KIND_DROP  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REPLY_NONE = 2'd0,
    REPLY_ZERO = 2'd1,
    REPLY_ONE  = 2'd2,
    REPLY_OK   = 2'd3
  } reply_t;

  typedef struct packed {
    logic             cmd;
    logic             source;
    logic [SYM_W-1:0] symbol;
    logic             frame_end;
  } item_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] head_drive;
    logic [DRIVE_W-1:0] tail_drive;
    logic               drive_written;
    logic               reset_request;
    reply_t             reply;
    logic               wireless_mode;
    logic               link_alive;
  } result_t;

  // handshake status shared between the pipeline registers
  typedef struct packed {
    logic go;
    logic has_result;
  } stage_ctl_t;

  function automatic logic [DRIVE_W-1:0] div10(input logic [VAL_W-1:0] v);
    logic [33:0] p;
    p = 34'(v) * 34'(DIV10_MUL);
    return p[DIV10_SHIFT +: DRIVE_W];
  endfunction

endpackage

// File: src/cfpw_if.sv
interface cfpw_item_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic                          src;
  logic [cfpw_pkg::SYM_W-1:0]    symbol;
  logic                          frame_end;

  modport source (output valid, cmd, src, symbol, frame_end, input ready);
  modport sink (input valid, cmd, src, symbol, frame_end, output ready);
endinterface

interface cfpw_result_if;
  logic                          valid;
  logic                          ready;
  logic [cfpw_pkg::DRIVE_W-1:0]  head_drive;
  logic [cfpw_pkg::DRIVE_W-1:0]  tail_drive;
  logic                          drive_written;
  logic                          reset_request;
  logic [1:0]                    reply;
  logic                          wireless_mode;
  logic                          link_alive;

  modport source (output valid, head_drive, tail_drive, drive_written, reset_request,
                  reply, wireless_mode, link_alive, input ready);
  modport sink (input valid, head_drive, tail_drive, drive_written, reset_request,
                reply, wireless_mode, link_alive, output ready);
endinterface

interface cfpw_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cfpw_pkg::CFG_IDX_W-1:0]  index;
  logic [cfpw_pkg::VAL_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: src/cfpw_in_reg.sv
module cfpw_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  cfpw_pkg::item_t     in_item,
  output logic                in_ready,
  input  logic                out_free,
  output cfpw_pkg::stage_ctl_t ctl_pre,
  output logic                s1_valid,
  output cfpw_pkg::item_t     s1_item
);

  logic            valid_r;
  cfpw_pkg::item_t item_r;
  logic            go;

  // request in the input register is processed when the result slot can take it
  assign go       = valid_r && out_free;
  assign in_ready = !valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign ctl_pre.go         = go;
  assign ctl_pre.has_result = 1'b0;
  assign s1_valid           = valid_r;
  assign s1_item            = item_r;

endmodule

// File: src/cfpw_core.sv
module cfpw_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  cfpw_pkg::item_t              item,
  input  logic [cfpw_pkg::VAL_W-1:0]   timeout_ms,
  input  logic [cfpw_pkg::VAL_W-1:0]   on_threshold,
  output cfpw_pkg::stage_ctl_t         ctl,
  output cfpw_pkg::result_t            res
);

  cfpw_pkg::kind_t                  kind_r, kind_nxt, cur_kind;
  logic                             mode_r, mode_nxt;
  logic                             alive_r, alive_nxt;
  logic [cfpw_pkg::VAL_W-1:0]       tick_r, tick_nxt;
  logic                             link_r, link_nxt;
  logic [cfpw_pkg::CNT_W-1:0]       cc_r, cc_nxt;
  logic [cfpw_pkg::NUM_PAT-1:0]     hits_r, hits_nxt;
  logic [1:0]                       fi_r, fi_nxt;
  logic                             dc_r, dc_nxt;
  logic [cfpw_pkg::VAL_W-1:0]       hv_r, hv_nxt;
  logic [cfpw_pkg::VAL_W-1:0]       tv_r, tv_nxt;
  logic [cfpw_pkg::DRIVE_W-1:0]     hd_r, hd_nxt;
  logic [cfpw_pkg::DRIVE_W-1:0]     td_r, td_nxt;
  logic                             kind_open;
  logic                             has_result;
  logic                             written;
  logic                             rst_req;
  cfpw_pkg::reply_t                 reply;

  // a character on the other link abandons the open frame
  assign kind_open = (kind_r != cfpw_pkg::KIND_NONE) && (item.source == link_r);

  always_comb begin
    cur_kind = kind_r;
    if (!kind_open) begin
      case (item.symbol)
        cfpw_pkg::SYM_A:  cur_kind = cfpw_pkg::KIND_CMD;
        cfpw_pkg::SYM_GT: cur_kind = cfpw_pkg::KIND_DRIVE;
        default:          cur_kind = cfpw_pkg::KIND_DROP;
      endcase
    end
    if (item.cmd) begin
      kind_nxt = kind_r;
    end else if (item.frame_end) begin
      kind_nxt = cfpw_pkg::KIND_NONE;
    end else begin
      kind_nxt = cur_kind;
    end
  end

  always_comb begin
    logic [cfpw_pkg::VAL_W:0]   tick_inc;
    logic [19:0]                acc;
    logic [cfpw_pkg::VAL_W-1:0] fval;
    logic [3:0]                 dig;
    logic [cfpw_pkg::VAL_W-1:0] fsat;
    logic [cfpw_pkg::NUM_PAT-1:0] hit;

    mode_nxt   = mode_r;
    alive_nxt  = alive_r;
    tick_nxt   = tick_r;
    link_nxt   = link_r;
    cc_nxt     = cc_r;
    hits_nxt   = hits_r;
    fi_nxt     = fi_r;
    dc_nxt     = dc_r;
    hv_nxt     = hv_r;
    tv_nxt     = tv_r;
    hd_nxt     = hd_r;
    td_nxt     = td_r;
    has_result = 1'b0;
    written    = 1'b0;
    rst_req    = 1'b0;
    reply      = cfpw_pkg::REPLY_NONE;
    tick_inc   = 17'(tick_r) + 17'd1;
    dig        = 4'(item.symbol - cfpw_pkg::SYM_ZERO);
    fval       = '0;
    acc        = '0;
    fsat       = '0;
    hit        = '0;

    if (item.cmd) begin
      if (tick_inc >= 17'(timeout_ms)) begin
        tick_nxt   = '0;
        alive_nxt  = 1'b0;
        hd_nxt     = '0;
        td_nxt     = '0;
        written    = 1'b1;
        has_result = 1'b1;
      end else begin
        tick_nxt = tick_inc[cfpw_pkg::VAL_W-1:0];
      end
    end else begin
      if (!kind_open) begin
        link_nxt = item.source;
        cc_nxt   = '0;
        hits_nxt = '1;
        fi_nxt   = '0;
        dc_nxt   = 1'b0;
        hv_nxt   = '0;
        tv_nxt   = '0;
      end

      if (cur_kind == cfpw_pkg::KIND_CMD) begin
        for (int k = 0; k < cfpw_pkg::NUM_PAT; k++) begin
          if (cc_nxt >= cfpw_pkg::PAT_LEN[k] ||
              cfpw_pkg::PAT_TEXT[k][cc_nxt] != item.symbol) begin
            hits_nxt[k] = 1'b0;
          end
        end
        if (cc_nxt != '1) begin
          cc_nxt = cc_nxt + 3'd1;
        end
      end else if (kind_open && kind_r == cfpw_pkg::KIND_DRIVE && fi_nxt < 2'd2) begin
        if (item.symbol == cfpw_pkg::SYM_COMMA) begin
          // empty fields between commas are skipped
          if (cc_nxt[0]) begin
            fi_nxt = fi_nxt + 2'd1;
            cc_nxt = '0;
            dc_nxt = 1'b0;
          end
        end else begin
          cc_nxt[0] = 1'b1;
          if (!dc_nxt && !(!cc_nxt[1] && (item.symbol == cfpw_pkg::SYM_SPACE ||
              item.symbol inside {[cfpw_pkg::SYM_TAB:cfpw_pkg::SYM_CR]}))) begin
            cc_nxt[1] = 1'b1;
            fval = (fi_nxt == 2'd0) ? hv_nxt : tv_nxt;
            if (item.symbol >= cfpw_pkg::SYM_ZERO && item.symbol <= cfpw_pkg::SYM_NINE) begin
              acc  = 20'({fval, 3'b000}) + 20'({fval, 1'b0}) + 20'(dig);
              fsat = (acc > 20'(cfpw_pkg::VAL_MAX)) ? cfpw_pkg::VAL_MAX
                                                    : acc[cfpw_pkg::VAL_W-1:0];
              if (fi_nxt == 2'd0) begin
                hv_nxt = fsat;
              end else begin
                tv_nxt = fsat;
              end
            end else begin
              dc_nxt = 1'b1;
            end
          end
        end
      end

      if (item.frame_end) begin
        has_result = 1'b1;
        if (cur_kind == cfpw_pkg::KIND_CMD) begin
          for (int k = 0; k < cfpw_pkg::NUM_PAT; k++) begin
            hit[k] = hits_nxt[k] && (cc_nxt == cfpw_pkg::PAT_LEN[k]);
          end
          if (hit[cfpw_pkg::PAT_RS]) begin
            rst_req = 1'b1;
          end else if (hit[cfpw_pkg::PAT_WL1] || hit[cfpw_pkg::PAT_WL0]) begin
            mode_nxt = hit[cfpw_pkg::PAT_WL1];
            hd_nxt   = '0;
            td_nxt   = '0;
            written  = 1'b1;
          end else if (hit[cfpw_pkg::PAT_WLQ]) begin
            reply = mode_r ? cfpw_pkg::REPLY_ONE : cfpw_pkg::REPLY_ZERO;
          end else if (hit[cfpw_pkg::PAT_AT]) begin
            reply = cfpw_pkg::REPLY_OK;
          end
          tick_nxt  = '0;
          alive_nxt = 1'b1;
        end else if (cur_kind == cfpw_pkg::KIND_DRIVE && (link_nxt ^ mode_r)) begin
          hd_nxt    = (hv_nxt >= on_threshold) ? cfpw_pkg::div10(hv_nxt) : '0;
          td_nxt    = (tv_nxt >= on_threshold) ? cfpw_pkg::div10(tv_nxt) : '0;
          written   = 1'b1;
          tick_nxt  = '0;
          alive_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= cfpw_pkg::KIND_NONE;
      mode_r  <= 1'b0;
      alive_r <= 1'b0;
      tick_r  <= '0;
      link_r  <= 1'b0;
      cc_r    <= '0;
      hits_r  <= '1;
      fi_r    <= '0;
      dc_r    <= 1'b0;
      hv_r    <= '0;
      tv_r    <= '0;
      hd_r    <= '0;
      td_r    <= '0;
    end else if (go) begin
      kind_r  <= kind_nxt;
      mode_r  <= mode_nxt;
      alive_r <= alive_nxt;
      tick_r  <= tick_nxt;
      link_r  <= link_nxt;
      cc_r    <= cc_nxt;
      hits_r  <= hits_nxt;
      fi_r    <= fi_nxt;
      dc_r    <= dc_nxt;
      hv_r    <= hv_nxt;
      tv_r    <= tv_nxt;
      hd_r    <= hd_nxt;
      td_r    <= td_nxt;
    end
  end

  assign ctl.go             = go;
  assign ctl.has_result     = has_result;
  assign res.head_drive     = hd_nxt;
  assign res.tail_drive     = td_nxt;
  assign res.drive_written  = written;
  assign res.reset_request  = rst_req;
  assign res.reply          = reply;
  assign res.wireless_mode  = mode_nxt;
  assign res.link_alive     = alive_nxt;

endmodule

// File: src/cfpw_out_reg.sv
module cfpw_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfpw_pkg::stage_ctl_t ctl,
  input  cfpw_pkg::result_t    res,
  input  logic                 out_ready,
  output logic                 out_free,
  output logic                 out_valid,
  output cfpw_pkg::result_t    out_res
);

  logic              valid_r;
  cfpw_pkg::result_t res_r;

  assign out_free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= ctl.go && ctl.has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.go && ctl.has_result) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// File: src/command_frame_parser_with_link_watchdog_top.sv
// a request's result is registered in the output register once the core takes it from the input register
// throughput: one request per cycle unless a waiting result holds the core; ticks and characters share one channel
// a result waiting on out_ch.ready holds the core; the input register then takes
// at most one more request before in_ch.ready drops
// reset (synchronous, rst_n low): wired link selected, drives zero, link dead,
// no frame open, timeout_ms and on_threshold back to 1000
module command_frame_parser_with_link_watchdog_top (
  input  logic            clk,
  input  logic            rst_n,
  cfpw_item_if.sink       in_ch,
  cfpw_result_if.source   out_ch,
  cfpw_cfg_if.sink        cfg_ch
);

  logic [cfpw_pkg::VAL_W-1:0] timeout_r;
  logic [cfpw_pkg::VAL_W-1:0] thresh_r;
  cfpw_pkg::item_t            in_item;
  cfpw_pkg::item_t            s1_item;
  logic                       s1_valid;
  logic                       out_free;
  cfpw_pkg::stage_ctl_t       ctl_pre;
  cfpw_pkg::stage_ctl_t       ctl;
  cfpw_pkg::result_t          res;
  cfpw_pkg::result_t          out_res;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= cfpw_pkg::TIMEOUT_RESET;
      thresh_r  <= cfpw_pkg::THRESH_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        cfpw_pkg::REG_TIMEOUT:   timeout_r <= cfg_ch.data;
        cfpw_pkg::REG_THRESHOLD: thresh_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign in_item.cmd       = in_ch.cmd;
  assign in_item.source    = in_ch.src;
  assign in_item.symbol    = in_ch.symbol;
  assign in_item.frame_end = in_ch.frame_end;

  cfpw_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_item  (in_item),
    .in_ready (in_ch.ready),
    .out_free (out_free),
    .ctl_pre  (ctl_pre),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  cfpw_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .go           (ctl_pre.go),
    .item         (s1_item),
    .timeout_ms   (timeout_r),
    .on_threshold (thresh_r),
    .ctl          (ctl),
    .res          (res)
  );

  cfpw_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .res       (res),
    .out_ready (out_ch.ready),
    .out_free  (out_free),
    .out_valid (out_ch.valid),
    .out_res   (out_res)
  );

  assign out_ch.head_drive    = out_res.head_drive;
  assign out_ch.tail_drive    = out_res.tail_drive;
  assign out_ch.drive_written = out_res.drive_written;
  assign out_ch.reset_request = out_res.reset_request;
  assign out_ch.reply         = out_res.reply;
  assign out_ch.wireless_mode = out_res.wireless_mode;
  assign out_ch.link_alive    = out_res.link_alive;

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid && out_ch.valid && !out_ch.ready)
    else $error("input stalled while the pipeline has room");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.head_drive <= 13'd6553 && out_ch.tail_drive <= 13'd6553)
    else $error("drive above value/10 range");

  a_reset_req_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.reset_request |->
      !out_ch.drive_written && out_ch.reply == cfpw_pkg::REPLY_NONE)
    else $error("reset request combined with another action");

  a_dead_link_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.drive_written && !out_ch.link_alive |->
      out_ch.head_drive == '0 && out_ch.tail_drive == '0)
    else $error("drives written nonzero on a dead link");
`endif

endmodule

// File: verif/tb_command_frame_parser_with_link_watchdog_top.sv
`timescale 1ns / 1ps

module tb_command_frame_parser_with_link_watchdog_top;
  import cfpw_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 650;
  localparam int SETTLE       = 4;
  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

  class link_scoreboard;
    logic [VAL_W-1:0]   timeout_ms;
    logic [VAL_W-1:0]   on_threshold;
    logic               mode_sel;
    logic               alive;
    logic [VAL_W-1:0]   tick_cnt;
    logic               frame_src;
    kind_t              kind;
    logic [CNT_W-1:0]   char_cnt;
    logic [NUM_PAT-1:0] hits;
    logic [1:0]         field_idx;
    logic               digits_done;
    logic [VAL_W-1:0]   head_val;
    logic [VAL_W-1:0]   tail_val;
    logic [DRIVE_W-1:0] head_drv;
    logic [DRIVE_W-1:0] tail_drv;
    string              cmd_text[NUM_PAT];
    result_t            pending_results[$];
    int                 errors;

    function new();
      cmd_text     = '{"ATRS", "ATWL=1", "ATWL=0", "ATWL?", "AT"};
      timeout_ms   = TIMEOUT_RESET;
      on_threshold = THRESH_RESET;
      mode_sel     = 1'b0;
      alive        = 1'b0;
      tick_cnt     = '0;
      frame_src    = 1'b0;
      kind         = KIND_NONE;
      char_cnt     = '0;
      hits         = '1;
      field_idx    = '0;
      digits_done  = 1'b0;
      head_val     = '0;
      tail_val     = '0;
      head_drv     = '0;
      tail_drv     = '0;
      errors       = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
      if (idx == REG_TIMEOUT) timeout_ms = data;
      else on_threshold = data;
    endfunction

    function logic [DRIVE_W-1:0] drive_for(logic [VAL_W-1:0] v);
      return (v >= on_threshold) ? DRIVE_W'(v / 10) : '0;
    endfunction

    function void match_cmd(logic [SYM_W-1:0] sym);
      int k;
      for (k = 0; k < NUM_PAT; k++) begin
        if (hits[k] && (char_cnt >= cmd_text[k].len() || cmd_text[k][char_cnt] != sym))
          hits[k] = 1'b0;
      end
      char_cnt = (char_cnt < 3'd7) ? char_cnt + 3'd1 : 3'd7;
    endfunction

    // char_cnt[0]: token open, char_cnt[1]: past leading blanks
    function void parse_field(logic [SYM_W-1:0] sym);
      int unsigned acc;
      if (field_idx >= 2'd2) return;
      if (sym == SYM_COMMA) begin
        if (char_cnt[0]) begin
          field_idx++;
          char_cnt    = '0;
          digits_done = 1'b0;
        end
        return;
      end
      char_cnt[0] = 1'b1;
      if (digits_done) return;
      if (!char_cnt[1] && (sym == SYM_SPACE || (sym >= SYM_TAB && sym <= SYM_CR))) return;
      char_cnt[1] = 1'b1;
      if (sym >= SYM_ZERO && sym <= SYM_NINE) begin
        acc = 32'(field_idx == 2'd0 ? head_val : tail_val) * 10 + 32'(sym - SYM_ZERO);
        if (acc > 65535) acc = 65535;
        if (field_idx == 2'd0) head_val = VAL_W'(acc);
        else tail_val = VAL_W'(acc);
      end else begin
        digits_done = 1'b1;
      end
    endfunction

    function void push_result(logic written, logic rst_req, reply_t rep);
      result_t r;
      r.head_drive    = head_drv;
      r.tail_drive    = tail_drv;
      r.drive_written = written;
      r.reset_request = rst_req;
      r.reply         = rep;
      r.wireless_mode = mode_sel;
      r.link_alive    = alive;
      pending_results.push_back(r);
    endfunction

    function void note_request(item_t req);
      logic [VAL_W:0]     t;
      logic [NUM_PAT-1:0] hit;
      logic               written;
      logic               rst_req;
      reply_t             rep;
      int                 k;
      if (req.cmd) begin
        t = tick_cnt + 17'd1;
        if (t >= {1'b0, timeout_ms}) begin
          tick_cnt = '0;
          alive    = 1'b0;
          head_drv = '0;
          tail_drv = '0;
          push_result(1'b1, 1'b0, REPLY_NONE);
        end else begin
          tick_cnt = t[VAL_W-1:0];
        end
        return;
      end
      // a character on the other link abandons the open frame
      if (kind != KIND_NONE && req.source != frame_src) kind = KIND_NONE;
      if (kind == KIND_NONE) begin
        frame_src   = req.source;
        char_cnt    = '0;
        hits        = '1;
        field_idx   = '0;
        digits_done = 1'b0;
        head_val    = '0;
        tail_val    = '0;
        if (req.symbol == SYM_A) begin
          kind = KIND_CMD;
          match_cmd(req.symbol);
        end else if (req.symbol == SYM_GT) begin
          kind = KIND_DRIVE;
        end else begin
          kind = KIND_DROP;
        end
      end else if (kind == KIND_CMD) begin
        match_cmd(req.symbol);
      end else if (kind == KIND_DRIVE) begin
        parse_field(req.symbol);
      end
      if (!req.frame_end) return;
      written = 1'b0;
      rst_req = 1'b0;
      rep     = REPLY_NONE;
      if (kind == KIND_CMD) begin
        for (k = 0; k < NUM_PAT; k++) hit[k] = hits[k] && char_cnt == cmd_text[k].len();
        if (hit[PAT_RS]) begin
          rst_req = 1'b1;
        end else if (hit[PAT_WL1] || hit[PAT_WL0]) begin
          mode_sel = hit[PAT_WL1];
          head_drv = '0;
          tail_drv = '0;
          written  = 1'b1;
        end else if (hit[PAT_WLQ]) begin
          rep = mode_sel ? REPLY_ONE : REPLY_ZERO;
        end else if (hit[PAT_AT]) begin
          rep = REPLY_OK;
        end
        tick_cnt = '0;
        alive    = 1'b1;
      end else if (kind == KIND_DRIVE && frame_src != mode_sel) begin
        // mode 0 takes the wired link (source 1), mode 1 the radio link
        head_drv = drive_for(head_val);
        tail_drv = drive_for(tail_val);
        written  = 1'b1;
        tick_cnt = '0;
        alive    = 1'b1;
      end
      kind = KIND_NONE;
      push_result(written, rst_req, rep);
    endfunction

    function void check_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0d, got %0d", name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(result_t seen);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result with no request waiting for it");
        errors++;
        return;
      end
      want = pending_results.pop_front();
      check_field("head_drive", 16'(want.head_drive), 16'(seen.head_drive));
      check_field("tail_drive", 16'(want.tail_drive), 16'(seen.tail_drive));
      check_field("drive_written", 16'(want.drive_written), 16'(seen.drive_written));
      check_field("reset_request", 16'(want.reset_request), 16'(seen.reset_request));
      check_field("reply", 16'(want.reply), 16'(seen.reply));
      check_field("wireless_mode", 16'(want.wireless_mode), 16'(seen.wireless_mode));
      check_field("link_alive", 16'(want.link_alive), 16'(seen.link_alive));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  cfpw_item_if   in_ch();
  cfpw_result_if out_ch();
  cfpw_cfg_if    cfg_ch();

  command_frame_parser_with_link_watchdog_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  link_scoreboard   sb;
  int               send_idle_pct;
  int               stall_pct;
  int               sent_items;
  int               cycle_count;
  logic             noisy;
  logic             mode_guess;
  logic [VAL_W-1:0] cur_threshold;
  logic [SYM_W-1:0] frame_buf[$];
  item_t            seen_req;
  result_t          seen_res;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) out_ch.ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      seen_res.head_drive    = out_ch.head_drive;
      seen_res.tail_drive    = out_ch.tail_drive;
      seen_res.drive_written = out_ch.drive_written;
      seen_res.reset_request = out_ch.reset_request;
      seen_res.reply         = reply_t'(out_ch.reply);
      seen_res.wireless_mode = out_ch.wireless_mode;
      seen_res.link_alive    = out_ch.link_alive;
      sb.check_result(seen_res);
    end
    if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
      seen_req.cmd       = in_ch.cmd;
      seen_req.source    = in_ch.src;
      seen_req.symbol    = in_ch.symbol;
      seen_req.frame_end = in_ch.frame_end;
      sb.note_request(seen_req);
    end
  end

  task automatic send_item(input item_t req);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= req.cmd;
    in_ch.src       <= req.source;
    in_ch.symbol    <= req.symbol;
    in_ch.frame_end <= req.frame_end;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sent_items++;
  endtask

  task automatic send_char(input logic src, input logic [SYM_W-1:0] sym, input logic last);
    item_t req;
    req.cmd       = 1'b0;
    req.source    = src;
    req.symbol    = sym;
    req.frame_end = last;
    send_item(req);
  endtask

  // character fields carry random junk on a tick
  task automatic send_tick();
    item_t req;
    req.cmd       = 1'b1;
    req.source    = 1'($urandom_range(1));
    req.symbol    = SYM_W'($urandom_range(255));
    req.frame_end = 1'($urandom_range(1));
    send_item(req);
  endtask

  task automatic send_frame(input logic src);
    int i;
    for (i = 0; i < frame_buf.size(); i++) begin
      if (noisy && $urandom_range(99) < 8) send_tick();
      if (noisy && i > 0 && $urandom_range(99) < 2)
        send_char(~src, SYM_W'($urandom_range(255)), 1'b0);
      send_char(src, frame_buf[i], i == frame_buf.size() - 1);
    end
  endtask

  function automatic void load_text(string txt);
    int i;
    frame_buf.delete();
    for (i = 0; i < txt.len(); i++) frame_buf.push_back(txt[i]);
  endfunction

  function automatic void add_field();
    int unsigned v;
    int unsigned hi;
    int          b;
    int          r;
    int          i;
    string       digits;
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(1, 2)) begin
        b = $urandom_range(9, 14);
        frame_buf.push_back(b == 14 ? SYM_SPACE : SYM_W'(b));
      end
    end
    if ($urandom_range(99) < 8) frame_buf.push_back($urandom_range(1) ? SYM_PLUS : SYM_MINUS);
    r  = $urandom_range(99);
    hi = 32'(cur_threshold) * 2 + 20;
    if (r < 35) v = $urandom_range(hi, 0);
    else if (r < 55) v = (cur_threshold == 0) ? $urandom_range(1) :
                         32'(cur_threshold) + $urandom_range(2) - 1;
    else if (r < 75) v = $urandom_range(65535);
    else v = $urandom_range(9999999, 65536);
    if (r < 90) begin
      if ($urandom_range(99) < 10) frame_buf.push_back(SYM_ZERO);
      digits = $sformatf("%0d", v);
      for (i = 0; i < digits.len(); i++) frame_buf.push_back(digits[i]);
    end
    // junk after the digits, sometimes followed by a nine that must be ignored
    if ($urandom_range(99) < 15) begin
      frame_buf.push_back(SYM_W'($urandom_range(255)));
      if ($urandom_range(1)) frame_buf.push_back(SYM_NINE);
    end
  endfunction

  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_config(input logic [VAL_W-1:0] tmo, input logic [VAL_W-1:0] thr);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_TIMEOUT;
    cfg_ch.data  <= tmo;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.set_reg(REG_TIMEOUT, tmo);
    cfg_ch.index <= REG_THRESHOLD;
    cfg_ch.data  <= thr;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.set_reg(REG_THRESHOLD, thr);
    cfg_ch.valid <= 1'b0;
    cur_threshold = thr;
  endtask

  task automatic run_directed();
    noisy = 1'b0;
    load_text("AT");
    send_frame(1'b0);
    load_text("ATRS");
    send_frame(1'b1);
    // wired link is selected after reset; head saturates, tail is under threshold
    load_text(">70000,999");
    send_frame(1'b1);
    load_text("ATWL=1");
    send_frame(1'b1);
    load_text("ATWL?");
    send_frame(1'b0);
    // now on the wrong link
    load_text(">5000");
    send_frame(1'b1);
    send_tick();
    mode_guess = 1'b1;
  endtask

  task automatic run_random(input int count);
    int   first;
    int   r;
    int   k;
    int   n;
    int   f;
    logic paused;
    logic src;
    logic [SYM_W-1:0] b;
    first  = sent_items;
    paused = 1'b0;
    noisy  = 1'b1;
    while (sent_items - first < count) begin
      if (!paused && sent_items - first >= count / 2) begin
        wait_quiet();
        paused = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 30) begin
        k = $urandom_range(NUM_PAT - 1);
        load_text(sb.cmd_text[k]);
        n = $urandom_range(99);
        if (n >= 90) begin
          f = $urandom_range(frame_buf.size() - 1, 1);
          while (frame_buf.size() > f) void'(frame_buf.pop_back());
        end else if (n >= 80) begin
          repeat ($urandom_range(1, 5)) frame_buf.push_back(SYM_W'($urandom_range(255)));
        end else if (n >= 70) begin
          frame_buf[$urandom_range(frame_buf.size() - 1, 1)] = SYM_W'($urandom_range(255));
        end
        send_frame(1'($urandom_range(1)));
        if (n < 70 && (k == PAT_WL1 || k == PAT_WL0)) mode_guess = (k == PAT_WL1);
      end else if (r < 75) begin
        frame_buf.delete();
        frame_buf.push_back(SYM_GT);
        if ($urandom_range(99) < 15) repeat ($urandom_range(1, 2)) frame_buf.push_back(SYM_COMMA);
        n = $urandom_range(3);
        for (f = 0; f < n; f++) begin
          if (f > 0) begin
            frame_buf.push_back(SYM_COMMA);
            if ($urandom_range(99) < 10) frame_buf.push_back(SYM_COMMA);
          end
          add_field();
        end
        src = ($urandom_range(9) < 8) ? ~mode_guess : mode_guess;
        send_frame(src);
      end else if (r < 85) begin
        frame_buf.delete();
        do b = SYM_W'($urandom_range(255)); while (b == SYM_A || b == SYM_GT);
        frame_buf.push_back(b);
        repeat ($urandom_range(4)) frame_buf.push_back(SYM_W'($urandom_range(255)));
        send_frame(1'($urandom_range(1)));
      end else if (r < 93) begin
        repeat ($urandom_range(1, 40)) send_tick();
      end else begin
        frame_buf.delete();
        frame_buf.push_back($urandom_range(1) ? SYM_A : SYM_GT);
        send_frame(1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_command_frame_parser_with_link_watchdog_top NOT OK");
    $finish;
  end

  initial begin
    int ph;
    sb            = new();
    send_idle_pct = 6;
    stall_pct     = 56;
    sent_items    = 0;
    noisy         = 1'b0;
    mode_guess    = 1'b0;
    cur_threshold = THRESH_RESET;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.cmd       <= 1'b0;
    in_ch.src       <= 1'b0;
    in_ch.symbol    <= '0;
    in_ch.frame_end <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= REG_TIMEOUT;
    cfg_ch.data     <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    wait_quiet();

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 6;
          stall_pct     = 56;
          // every tick times out, every value drives
          write_config(16'd1, 16'd0);
        end
        1: begin
          send_idle_pct = 56;
          stall_pct     = 6;
          write_config(16'hFFFF, 16'hFFFF);
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          write_config(VAL_W'($urandom_range(60, 5)), VAL_W'($urandom_range(3000)));
        end
      endcase
      run_random((RANDOM_ITEMS + 2) / 3);
      wait_quiet();
    end

    if (sb.errors == 0) begin
      $display("tb_command_frame_parser_with_link_watchdog_top OK");
    end else begin
      $display("tb_command_frame_parser_with_link_watchdog_top NOT OK");
    end
    $finish;
  end

endmodule
